// File: rtl/core/sld_pkg.sv
package sld_pkg;

  // Framing characters of the byte stream.
  localparam logic [7:0] CharOpen  = 8'h28;
  localparam logic [7:0] CharClose = 8'h29;
  localparam logic [7:0] CharColon = 8'h3A;
  localparam logic [7:0] CharZero  = 8'h30;
  localparam logic [7:0] CharNine  = 8'h39;

  // Decimal base of the length prefix.
  localparam int unsigned LenBase = 10;

  // Element limit after reset.
  localparam logic [7:0] MaxElemReset = 8'd16;

  // Result kinds.
  typedef enum logic [1:0] {
    KindData  = 2'd0,
    KindEmpty = 2'd1,
    KindEnd   = 2'd2,
    KindError = 2'd3
  } kind_e;

  // Error codes carried with an error result.
  typedef enum logic [2:0] {
    ErrStart = 3'd0,
    ErrDigit = 3'd1,
    ErrEmpty = 3'd2,
    ErrOver  = 3'd3,
    ErrMany  = 3'd4
  } err_e;

  // One result item.
  typedef struct packed {
    kind_e       kind;
    logic [7:0]  data_byte;
    logic [7:0]  element_index;
    logic        last_in_element;
    err_e        error_code;
  } result_t;

  // What the parser produces for one byte: a result or none.
  typedef struct packed {
    logic    valid;
    result_t res;
  } step_out_t;

endpackage

// File: rtl/core/sld_if.sv
// Raw byte request channel.
interface sld_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] in_byte;

  modport source (output valid, output in_byte, input ready);
  modport sink   (input valid, input in_byte, output ready);
endinterface

// Result request channel.
interface sld_out_if;
  logic       valid;
  logic       ready;
  logic [1:0] kind;
  logic [7:0] data_byte;
  logic [7:0] element_index;
  logic       last_in_element;
  logic [2:0] error_code;

  modport source (output valid, output kind, output data_byte, output element_index,
                  output last_in_element, output error_code, input ready);
  modport sink   (input valid, input kind, input data_byte, input element_index,
                  input last_in_element, input error_code, output ready);
endinterface

// Configuration write channel for the element limit.
interface sld_cfg_if;
  logic       valid;
  logic       ready;
  logic [7:0] max_elements;

  modport source (output valid, output max_elements, input ready);
  modport sink   (input valid, input max_elements, output ready);
endinterface

// File: rtl/core/sld_parse.sv
module sld_parse #(
  parameter int unsigned LENGTH_BITS = 16
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 step_i,
  input  logic [7:0]           byte_i,
  input  logic [7:0]           max_elem_i,
  output sld_pkg::step_out_t   step_o
);

  typedef enum logic [1:0] {
    PhIdle = 2'd0,
    PhLen  = 2'd1,
    PhData = 2'd2,
    PhWait = 2'd3
  } phase_e;

  localparam int unsigned AccW = LENGTH_BITS + 4;

  phase_e                 phase_q, phase_d;
  logic [LENGTH_BITS-1:0] acc_q, acc_d;
  logic                   have_digit_q, have_digit_d;
  logic [LENGTH_BITS-1:0] left_q, left_d;
  logic [7:0]             count_q, count_d;

  logic [AccW-1:0]        acc_ext;
  logic [AccW-1:0]        acc_x10;
  logic                   overflow;
  logic                   is_digit;
  logic                   last_byte;
  logic                   fail;
  sld_pkg::err_e          fail_code;

  // Next decimal length: times ten as two shifts, plus the digit.
  assign acc_ext  = {4'b0000, acc_q};
  assign acc_x10  = (acc_ext << 3) + (acc_ext << 1) + AccW'(byte_i[3:0]);
  assign overflow = |acc_x10[AccW-1:LENGTH_BITS];
  assign is_digit = byte_i inside {[sld_pkg::CharZero:sld_pkg::CharNine]};

  // The final payload byte of an element is the one with at most one left.
  assign last_byte = (left_q[LENGTH_BITS-1:1] == '0);

  // Parse one byte against the current phase.
  always_comb begin
    phase_d      = phase_q;
    acc_d        = acc_q;
    have_digit_d = have_digit_q;
    left_d       = left_q;
    count_d      = count_q;
    step_o       = '0;
    fail         = 1'b0;
    fail_code    = sld_pkg::ErrStart;

    case (phase_q)
      PhIdle, PhWait: begin
        if (byte_i == sld_pkg::CharOpen) begin
          phase_d      = PhLen;
          acc_d        = '0;
          have_digit_d = 1'b0;
          left_d       = '0;
          count_d      = '0;
        end else if (phase_q == PhIdle) begin
          fail      = 1'b1;
          fail_code = sld_pkg::ErrStart;
        end
      end
      PhLen: begin
        if (byte_i == sld_pkg::CharClose) begin
          if (have_digit_q) begin
            fail      = 1'b1;
            fail_code = sld_pkg::ErrDigit;
          end else begin
            phase_d                    = PhIdle;
            acc_d                      = '0;
            have_digit_d               = 1'b0;
            count_d                    = '0;
            step_o.valid               = 1'b1;
            step_o.res.kind            = sld_pkg::KindEnd;
            step_o.res.element_index   = count_q;
          end
        end else if (!have_digit_q && (count_q >= max_elem_i)) begin
          fail      = 1'b1;
          fail_code = sld_pkg::ErrMany;
        end else if (is_digit) begin
          if (overflow) begin
            fail      = 1'b1;
            fail_code = sld_pkg::ErrOver;
          end else begin
            acc_d        = acc_x10[LENGTH_BITS-1:0];
            have_digit_d = 1'b1;
          end
        end else if (byte_i == sld_pkg::CharColon) begin
          if (!have_digit_q) begin
            fail      = 1'b1;
            fail_code = sld_pkg::ErrEmpty;
          end else if (acc_q == '0) begin
            // Zero length: one empty marker, stay in the length phase.
            count_d                  = count_q + 8'd1;
            acc_d                    = '0;
            have_digit_d             = 1'b0;
            step_o.valid             = 1'b1;
            step_o.res.kind          = sld_pkg::KindEmpty;
            step_o.res.element_index = count_q;
          end else begin
            left_d       = acc_q;
            phase_d      = PhData;
            acc_d        = '0;
            have_digit_d = 1'b0;
          end
        end else begin
          fail      = 1'b1;
          fail_code = sld_pkg::ErrDigit;
        end
      end
      PhData: begin
        step_o.valid               = 1'b1;
        step_o.res.kind            = sld_pkg::KindData;
        step_o.res.data_byte       = byte_i;
        step_o.res.element_index   = count_q;
        step_o.res.last_in_element = last_byte;
        if (last_byte) begin
          left_d       = '0;
          count_d      = count_q + 8'd1;
          phase_d      = PhLen;
          acc_d        = '0;
          have_digit_d = 1'b0;
        end else begin
          left_d = left_q - LENGTH_BITS'(1);
        end
      end
      default: begin
        phase_d = PhIdle;
      end
    endcase

    // Any error drops the message and waits for an opening paren.
    if (fail) begin
      phase_d         = PhWait;
      acc_d           = '0;
      have_digit_d    = 1'b0;
      left_d          = '0;
      count_d         = '0;
      step_o          = '0;
      step_o.valid    = 1'b1;
      step_o.res.kind = sld_pkg::KindError;
      step_o.res.error_code = fail_code;
    end
  end

  // Parser state advances once per processed byte.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q      <= PhIdle;
      acc_q        <= '0;
      have_digit_q <= 1'b0;
      left_q       <= '0;
      count_q      <= '0;
    end else if (step_i) begin
      phase_q      <= phase_d;
      acc_q        <= acc_d;
      have_digit_q <= have_digit_d;
      left_q       <= left_d;
      count_q      <= count_d;
    end
  end

endmodule

// File: rtl/core/sexp_list_deframer.sv
// Chan   Mode    Payload                                                     Role
// in_i   sink    in_byte[7:0]                                                raw framed bytes
// res_o  source  kind, data_byte, element_index, last_in_element, error_code results
// cfg_i  sink    max_elements[7:0]                                           element limit
//
// One byte is taken per cycle while res_o does not stall. An accepted byte waits in
// the input register; its result, if it yields one, loads into the result register.
// The parser step between the input register and the result register is combinational
// and holds the length multiply by ten.
// A stall on res_o holds the parser; in_i takes one more byte into its register first.
// Reset is asynchronous, active low, and leaves the block idle awaiting an open paren.
module sexp_list_deframer #(
  parameter int unsigned LENGTH_BITS = 16
) (
  input  logic      clk_i,
  input  logic      rst_ni,
  sld_in_if.sink    in_i,
  sld_out_if.source res_o,
  sld_cfg_if.sink   cfg_i
);

  logic               in_valid_q;
  logic [7:0]         in_byte_q;
  logic               res_valid_q;
  sld_pkg::result_t   res_q;
  logic [7:0]         max_elem_q;
  logic               out_free;
  logic               advance;
  sld_pkg::step_out_t step;

  // The parser moves when a byte waits and the result register can take its outcome.
  assign out_free  = !res_valid_q || res_o.ready;
  assign advance   = in_valid_q && out_free;
  assign in_i.ready = !in_valid_q || advance;
  assign cfg_i.ready = 1'b1;

  // Input register.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
    end else if (in_i.valid && in_i.ready) begin
      in_valid_q <= 1'b1;
    end else if (advance) begin
      in_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_i.valid && in_i.ready) begin
      in_byte_q <= in_i.in_byte;
    end
  end

  // Element limit register.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      max_elem_q <= sld_pkg::MaxElemReset;
    end else if (cfg_i.valid) begin
      max_elem_q <= cfg_i.max_elements;
    end
  end

  sld_parse #(
    .LENGTH_BITS(LENGTH_BITS)
  ) u_parse (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .step_i     (advance),
    .byte_i     (in_byte_q),
    .max_elem_i (max_elem_q),
    .step_o     (step)
  );

  // Result register.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      res_valid_q <= 1'b0;
    end else if (advance) begin
      res_valid_q <= step.valid;
    end else if (res_o.ready) begin
      res_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (advance && step.valid) begin
      res_q <= step.res;
    end
  end

  assign res_o.valid           = res_valid_q;
  assign res_o.kind            = res_q.kind;
  assign res_o.data_byte       = res_q.data_byte;
  assign res_o.element_index   = res_q.element_index;
  assign res_o.last_in_element = res_q.last_in_element;
  assign res_o.error_code      = res_q.error_code;

endmodule

// File: rtl/core/sld_checker.sv
module sld_checker (
  input logic       clk_i,
  input logic       rst_ni,
  input logic       res_valid_i,
  input logic       res_ready_i,
  input logic [1:0] kind_i,
  input logic [7:0] data_byte_i,
  input logic [7:0] element_index_i,
  input logic       last_i,
  input logic [2:0] error_code_i
);

  // A stalled result keeps its request and payload.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_valid_i && !res_ready_i |=> res_valid_i && $stable(kind_i) && $stable(data_byte_i)
      && $stable(element_index_i) && $stable(last_i) && $stable(error_code_i))
    else $error("result changed while stalled");

  // Error results carry a defined code and nothing else.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_valid_i && (kind_i == sld_pkg::KindError) |->
      (data_byte_i == 8'd0) && (element_index_i == 8'd0) && !last_i &&
      ((error_code_i == sld_pkg::ErrStart) || (error_code_i == sld_pkg::ErrDigit) ||
       (error_code_i == sld_pkg::ErrEmpty) || (error_code_i == sld_pkg::ErrOver) ||
       (error_code_i == sld_pkg::ErrMany)))
    else $error("malformed error result");

  // Only data bytes may mark the end of an element; only errors may carry a nonzero code.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_valid_i && (kind_i != sld_pkg::KindData) |-> !last_i
      && ((kind_i == sld_pkg::KindError) || (error_code_i == sld_pkg::ErrStart)))
    else $error("stray flag on a non-data result");

  // Bytes of one element after a non-final byte keep the same index.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_valid_i && res_ready_i && (kind_i == sld_pkg::KindData) && !last_i ##1
      res_valid_i && (kind_i == sld_pkg::KindData) |->
      (element_index_i == $past(element_index_i)))
    else $error("element index changed inside an element");

endmodule

bind sexp_list_deframer sld_checker u_sld_checker (
  .clk_i           (clk_i),
  .rst_ni          (rst_ni),
  .res_valid_i     (res_o.valid),
  .res_ready_i     (res_o.ready),
  .kind_i          (res_o.kind),
  .data_byte_i     (res_o.data_byte),
  .element_index_i (res_o.element_index),
  .last_i          (res_o.last_in_element),
  .error_code_i    (res_o.error_code)
);
